// ===== design/csrgb_pkg.sv =====
// csrgb_pkg: shared types and constants for the csr graph builder
// field widths, command and status codes, shared adder operations
// no dependencies
package csrgb_pkg;

  localparam int DEF_EDGE_SLOTS   = 4096;
  localparam int DEF_MAX_VERTICES = 1024;

  localparam int CMD_W  = 3;
  localparam int VTX_W  = 10;
  localparam int IDX_W  = 13;
  localparam int VAL_W  = 13;
  localparam int VCNT_W = 11;
  localparam int ECNT_W = 13;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_LOAD     = 3'd1,
    CMD_BUILD    = 3'd2,
    CMD_READ_OFF = 3'd3,
    CMD_READ_NB  = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD  = 2'd0,
    ALU_INC  = 2'd1,
    ALU_PASS = 2'd2
  } alu_op_e;

endpackage

// ===== design/csrgb_alu.sv =====
// csrgb_alu: shared adder for degree counting, prefix sums and cursor bumps
// depends on csrgb_pkg
module csrgb_alu import csrgb_pkg::*; #(
  parameter int W = 13
) (
  input  alu_op_e        op_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [W-1:0]   sum_o
);

  always_comb begin
    case (op_i)
      ALU_ADD: sum_o = a_i + b_i;
      ALU_INC: sum_o = a_i + W'(1);
      default: sum_o = a_i;
    endcase
  end

endmodule

// ===== design/csr_graph_builder_core.sv =====
// csr_graph_builder_core: builds a compressed sparse row graph from loaded edges
// holds the edge, offset, cursor and neighbor memories and the build sequencer
// depends on csrgb_pkg and csrgb_alu
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   command, tail_vertex, head_vertex, read_index
// out      out  out_valid_o / out_ready_i read_value, vertex_count, edge_count, status
//
// clear, load and unused commands: the result is registered from the final state
// reads: a wait state covers the registered memory read before the final state
// build: clears the offsets, counts degrees, sums them and scatters the E loaded edges;
// each edge does a read-increment-write on the offset memory, then on the cursor memory
// in_ready_o is high only while the sequencer is idle; a waiting result holds the
// sequencer in its final state. reset clears counters and flags, memories need none
module csr_graph_builder_core import csrgb_pkg::*; #(
  parameter int EDGE_SLOTS   = DEF_EDGE_SLOTS,
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [VTX_W-1:0]  tail_vertex_i,
  input  logic [VTX_W-1:0]  head_vertex_i,
  input  logic [IDX_W-1:0]  read_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VAL_W-1:0]  read_value_o,
  output logic [VCNT_W-1:0] vertex_count_o,
  output logic [ECNT_W-1:0] edge_count_o,
  output logic [STAT_W-1:0] status_o
);

  localparam int EAW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
  localparam int ECW = $clog2(EDGE_SLOTS + 1);
  localparam int VAW = $clog2(MAX_VERTICES + 1);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int RO_DEPTH = MAX_VERTICES + 1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RDW   = 13'b0000000000010,
    S_FIN   = 13'b0000000000100,
    S_CLR   = 13'b0000000001000,
    S_CNT_A = 13'b0000000010000,
    S_CNT_B = 13'b0000000100000,
    S_CNT_C = 13'b0000001000000,
    S_PFX_A = 13'b0000010000000,
    S_PFX_B = 13'b0000100000000,
    S_SCT_A = 13'b0001000000000,
    S_SCT_B = 13'b0010000000000,
    S_SCT_C = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [ECW-1:0]   e_q, e_d;
  logic [VCW-1:0]   v_q, v_d;
  logic [VCW-1:0]   nv_q, nv_d;
  logic [ECW-1:0]   acc_q, acc_d;
  logic [ECW-1:0]   loaded_q, loaded_d;
  logic [VTX_W-1:0] largest_q, largest_d;
  logic [VCW-1:0]   built_q, built_d;
  logic             is_built_q, is_built_d;
  logic [VAL_W-1:0] res_value_q, res_value_d;
  status_e          res_status_q, res_status_d;
  logic             res_ok_q, res_ok_d;
  logic             rd_sel_q, rd_sel_d;

  logic [VTX_W-1:0] edge_tails [EDGE_SLOTS];
  logic [VTX_W-1:0] edge_heads [EDGE_SLOTS];
  logic [ECW-1:0]   row_offsets [RO_DEPTH];
  logic [ECW-1:0]   fill_cursor [RO_DEPTH];
  logic [VTX_W-1:0] neighbor_list [EDGE_SLOTS];

  logic             et_we, et_re;
  logic [EAW-1:0]   et_addr;
  logic [VTX_W-1:0] tail_rd_q, head_rd_q;
  logic             ro_we, ro_re;
  logic [VAW-1:0]   ro_waddr, ro_raddr;
  logic [ECW-1:0]   ro_wdata, ro_rd_q;
  logic             cur_we, cur_re;
  logic [VAW-1:0]   cur_waddr, cur_raddr;
  logic [ECW-1:0]   cur_wdata, cur_rd_q;
  logic             nl_we, nl_re;
  logic [EAW-1:0]   nl_waddr, nl_raddr;
  logic [VTX_W-1:0] nl_wdata, nl_rd_q;

  alu_op_e          alu_op;
  logic [ECW-1:0]   alu_a, alu_b, alu_sum;

  logic [31:0]      tail_p1;
  logic [31:0]      nv_raw;
  logic             t_in_range;
  logic             load_full, load_range;
  logic             out_free;
  logic [ECW-1:0]   e_next;

  csrgb_alu #(.W(ECW)) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_o || out_ready_i;
  assign tail_p1    = 32'(tail_rd_q) + 32'd1;
  assign t_in_range = 32'(tail_rd_q) < 32'(nv_q);
  assign load_full  = 32'(loaded_q) >= 32'(EDGE_SLOTS);
  assign load_range = (32'(tail_vertex_i) >= 32'(MAX_VERTICES)) ||
                      (32'(head_vertex_i) >= 32'(MAX_VERTICES));
  assign nv_raw     = (loaded_q == '0) ? 32'd1 : 32'(largest_q) + 32'd1;
  assign e_next     = e_q + ECW'(1);

  always_comb begin
    state_d      = state_q;
    e_d          = e_q;
    v_d          = v_q;
    nv_d         = nv_q;
    acc_d        = acc_q;
    loaded_d     = loaded_q;
    largest_d    = largest_q;
    built_d      = built_q;
    is_built_d   = is_built_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    res_ok_d     = res_ok_q;
    rd_sel_d     = rd_sel_q;
    et_we        = 1'b0;
    et_re        = 1'b0;
    et_addr      = EAW'(e_q);
    ro_we        = 1'b0;
    ro_re        = 1'b0;
    ro_waddr     = VAW'(v_q);
    ro_raddr     = VAW'(v_q);
    ro_wdata     = '0;
    cur_we       = 1'b0;
    cur_re       = 1'b0;
    cur_waddr    = VAW'(tail_rd_q);
    cur_raddr    = VAW'(tail_rd_q);
    cur_wdata    = alu_sum;
    nl_we        = 1'b0;
    nl_re        = 1'b0;
    nl_waddr     = EAW'(cur_rd_q);
    nl_raddr     = EAW'(read_index_i);
    nl_wdata     = head_rd_q;
    alu_op       = ALU_PASS;
    alu_a        = '0;
    alu_b        = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_value_d  = '0;
          res_status_d = ST_OK;
          state_d      = S_FIN;
          case (cmd_e'(command_i))
            CMD_CLEAR: begin
              loaded_d   = '0;
              largest_d  = '0;
              built_d    = '0;
              is_built_d = 1'b0;
            end
            CMD_LOAD: begin
              if (load_full) begin
                res_status_d = ST_FULL;
              end else if (load_range) begin
                res_status_d = ST_RANGE;
              end else begin
                et_we      = 1'b1;
                et_addr    = loaded_q[EAW-1:0];
                loaded_d   = loaded_q + ECW'(1);
                is_built_d = 1'b0;
                if (tail_vertex_i > largest_q && tail_vertex_i >= head_vertex_i) begin
                  largest_d = tail_vertex_i;
                end else if (head_vertex_i > largest_q) begin
                  largest_d = head_vertex_i;
                end
              end
            end
            CMD_BUILD: begin
              nv_d    = (nv_raw > 32'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : VCW'(nv_raw);
              v_d     = '0;
              state_d = S_CLR;
            end
            CMD_READ_OFF: begin
              ro_re    = 1'b1;
              ro_raddr = VAW'(read_index_i);
              res_ok_d = is_built_q && (32'(read_index_i) <= 32'(built_q));
              rd_sel_d = 1'b0;
              state_d  = S_RDW;
            end
            CMD_READ_NB: begin
              nl_re    = 1'b1;
              res_ok_d = is_built_q && (32'(read_index_i) < 32'(loaded_q));
              rd_sel_d = 1'b1;
              state_d  = S_RDW;
            end
            default: begin
              res_status_d = ST_OK;
            end
          endcase
        end
      end
      S_RDW: begin
        if (!res_ok_q) begin
          res_value_d  = '0;
          res_status_d = ST_BAD;
        end else begin
          res_value_d  = rd_sel_q ? VAL_W'(nl_rd_q) : VAL_W'(ro_rd_q);
          res_status_d = ST_OK;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        ro_we    = 1'b1;
        ro_wdata = '0;
        if (v_q == nv_q) begin
          v_d     = '0;
          e_d     = '0;
          acc_d   = '0;
          state_d = (loaded_q == '0) ? S_PFX_A : S_CNT_A;
        end else begin
          v_d = v_q + VCW'(1);
        end
      end
      S_CNT_A: begin
        et_re   = 1'b1;
        state_d = S_CNT_B;
      end
      S_CNT_B: begin
        ro_re    = 1'b1;
        ro_raddr = tail_p1[VAW-1:0];
        state_d  = S_CNT_C;
      end
      S_CNT_C: begin
        alu_op   = ALU_INC;
        alu_a    = ro_rd_q;
        ro_we    = t_in_range;
        ro_waddr = tail_p1[VAW-1:0];
        ro_wdata = alu_sum;
        e_d      = e_next;
        if (e_next == loaded_q) begin
          v_d     = '0;
          state_d = S_PFX_A;
        end else begin
          state_d = S_CNT_A;
        end
      end
      S_PFX_A: begin
        ro_re   = 1'b1;
        state_d = S_PFX_B;
      end
      S_PFX_B: begin
        alu_op    = ALU_ADD;
        alu_a     = acc_q;
        alu_b     = ro_rd_q;
        ro_we     = 1'b1;
        ro_wdata  = alu_sum;
        cur_we    = 1'b1;
        cur_waddr = VAW'(v_q);
        acc_d     = alu_sum;
        if (v_q == nv_q) begin
          e_d     = '0;
          state_d = (loaded_q == '0) ? S_DONE : S_SCT_A;
        end else begin
          v_d     = v_q + VCW'(1);
          state_d = S_PFX_A;
        end
      end
      S_SCT_A: begin
        et_re   = 1'b1;
        state_d = S_SCT_B;
      end
      S_SCT_B: begin
        cur_re  = 1'b1;
        state_d = S_SCT_C;
      end
      S_SCT_C: begin
        alu_op = ALU_INC;
        alu_a  = cur_rd_q;
        cur_we = t_in_range;
        nl_we  = t_in_range && (32'(cur_rd_q) < 32'(EDGE_SLOTS));
        e_d    = e_next;
        state_d = (e_next == loaded_q) ? S_DONE : S_SCT_A;
      end
      S_DONE: begin
        built_d      = nv_q;
        is_built_d   = 1'b1;
        res_value_d  = '0;
        res_status_d = ST_OK;
        state_d      = S_FIN;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      loaded_q   <= '0;
      largest_q  <= '0;
      built_q    <= '0;
      is_built_q <= 1'b0;
      e_q        <= '0;
      v_q        <= '0;
      nv_q       <= '0;
      acc_q      <= '0;
    end else begin
      state_q    <= state_d;
      loaded_q   <= loaded_d;
      largest_q  <= largest_d;
      built_q    <= built_d;
      is_built_q <= is_built_d;
      e_q        <= e_d;
      v_q        <= v_d;
      nv_q       <= nv_d;
      acc_q      <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    res_ok_q     <= res_ok_d;
    rd_sel_q     <= rd_sel_d;
  end

  // edge stores
  always_ff @(posedge clk_i) begin
    if (et_we) begin
      edge_tails[et_addr] <= tail_vertex_i;
      edge_heads[et_addr] <= head_vertex_i;
    end
    if (et_re) begin
      tail_rd_q <= edge_tails[et_addr];
      head_rd_q <= edge_heads[et_addr];
    end
  end

  // row offsets
  always_ff @(posedge clk_i) begin
    if (ro_we) begin
      row_offsets[ro_waddr] <= ro_wdata;
    end
    if (ro_re) begin
      ro_rd_q <= row_offsets[ro_raddr];
    end
  end

  // fill cursors
  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      fill_cursor[cur_waddr] <= cur_wdata;
    end
    if (cur_re) begin
      cur_rd_q <= fill_cursor[cur_raddr];
    end
  end

  // neighbor store
  always_ff @(posedge clk_i) begin
    if (nl_we) begin
      neighbor_list[nl_waddr] <= nl_wdata;
    end
    if (nl_re) begin
      nl_rd_q <= neighbor_list[nl_raddr];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == S_FIN && out_free) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && out_free) begin
      read_value_o   <= res_value_q;
      vertex_count_o <= VCNT_W'(built_q);
      edge_count_o   <= ECNT_W'(loaded_q);
      status_o       <= res_status_q;
    end
  end

  a_built_by_sequencer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(is_built_q) |-> $past(state_q == S_DONE))
    else $error("built flag set outside the build sequence");

  a_slot_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCT_C && t_in_range) |-> (32'(cur_rd_q) < 32'(loaded_q)))
    else $error("scatter slot beyond loaded edges");

  a_prefix_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PFX_B && v_q == nv_q) |-> (alu_sum == loaded_q))
    else $error("degree total differs from edge count");

  a_load_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && command_i == CMD_LOAD && !load_full && !load_range)
      |=> (loaded_q == $past(loaded_q) + ECW'(1)))
    else $error("accepted edge not counted");

endmodule

// ===== tb/csr_graph_builder_core_checker.sv =====
// csr_graph_builder_core_checker: scoreboard for the csr graph builder core
// watches the request and result channels, predicts each result from its own copy
// of the edge, offset and neighbor stores; depends on csrgb_pkg
module csr_graph_builder_core_checker import csrgb_pkg::*; #(
  parameter int EDGE_SLOTS   = DEF_EDGE_SLOTS,
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [VTX_W-1:0]  tail_vertex_i,
  input  logic [VTX_W-1:0]  head_vertex_i,
  input  logic [IDX_W-1:0]  read_index_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [VAL_W-1:0]  read_value_i,
  input  logic [VCNT_W-1:0] vertex_count_i,
  input  logic [ECNT_W-1:0] edge_count_i,
  input  logic [STAT_W-1:0] status_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [VCNT_W-1:0] vcount;
    logic [ECNT_W-1:0] ecount;
    status_e           status;
  } csr_result_t;

  csr_result_t expected_q[$];
  csr_result_t oldest;

  logic [VTX_W-1:0] edge_tail_mem [EDGE_SLOTS];
  logic [VTX_W-1:0] edge_head_mem [EDGE_SLOTS];
  logic [VAL_W-1:0] row_offset_mem [MAX_VERTICES+1];
  logic [VTX_W-1:0] neighbor_mem [EDGE_SLOTS];
  int unsigned      fill_pos [MAX_VERTICES+1];
  int unsigned      edges_held;
  int unsigned      top_vertex;
  int unsigned      vertices_built;
  bit               graph_ready;

  int fail_count = 0;
  int pending_count = 0;
  int checked_count = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;
  assign checked_o    = checked_count;

  // counting sort of the loaded edges by tail vertex
  task automatic build_rows();
    int unsigned nv;
    int unsigned t;
    nv = (edges_held == 0) ? 1 : top_vertex + 1;
    if (nv > MAX_VERTICES) nv = MAX_VERTICES;
    for (int unsigned v = 0; v <= nv; v++) row_offset_mem[v] = '0;
    for (int unsigned e = 0; e < edges_held; e++) begin
      t = 32'(edge_tail_mem[e]);
      if (t < nv) row_offset_mem[t+1] = row_offset_mem[t+1] + 1'b1;
    end
    for (int unsigned v = 0; v < nv; v++)
      row_offset_mem[v+1] = row_offset_mem[v+1] + row_offset_mem[v];
    for (int unsigned v = 0; v <= nv; v++) fill_pos[v] = 32'(row_offset_mem[v]);
    for (int unsigned e = 0; e < edges_held; e++) begin
      t = 32'(edge_tail_mem[e]);
      if (t < nv) begin
        if (fill_pos[t] < EDGE_SLOTS) neighbor_mem[fill_pos[t]] = edge_head_mem[e];
        fill_pos[t]++;
      end
    end
    vertices_built = nv;
    graph_ready = 1'b1;
  endtask

  task automatic predict_csr_result(input logic [CMD_W-1:0] cmd, input logic [VTX_W-1:0] tail,
                                    input logic [VTX_W-1:0] head, input logic [IDX_W-1:0] idx,
                                    output csr_result_t res);
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_CLEAR: begin
        edges_held = 0;
        top_vertex = 0;
        vertices_built = 0;
        graph_ready = 1'b0;
      end
      CMD_LOAD: begin
        if (edges_held >= EDGE_SLOTS) begin
          res.status = ST_FULL;
        end else if (tail >= MAX_VERTICES || head >= MAX_VERTICES) begin
          res.status = ST_RANGE;
        end else begin
          edge_tail_mem[edges_held] = tail;
          edge_head_mem[edges_held] = head;
          edges_held++;
          if (tail > top_vertex) top_vertex = 32'(tail);
          if (head > top_vertex) top_vertex = 32'(head);
          graph_ready = 1'b0;
        end
      end
      CMD_BUILD: build_rows();
      CMD_READ_OFF: begin
        if (!graph_ready || idx > vertices_built) res.status = ST_BAD;
        else res.value = row_offset_mem[idx];
      end
      CMD_READ_NB: begin
        if (!graph_ready || idx >= edges_held) res.status = ST_BAD;
        else res.value = VAL_W'(neighbor_mem[idx]);
      end
      default: ;
    endcase
    res.vcount = VCNT_W'(vertices_built);
    res.ecount = ECNT_W'(edges_held);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      edges_held = 0;
      top_vertex = 0;
      vertices_built = 0;
      graph_ready = 1'b0;
      pending_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no request waiting");
          fail_count++;
        end else begin
          oldest = expected_q.pop_front();
          check_field("read_value", 32'(oldest.value), 32'(read_value_i));
          check_field("vertex_count", 32'(oldest.vcount), 32'(vertex_count_i));
          check_field("edge_count", 32'(oldest.ecount), 32'(edge_count_i));
          check_field("status", 32'(oldest.status), 32'(status_i));
          checked_count++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_csr_result(command_i, tail_vertex_i, head_vertex_i, read_index_i, oldest);
        expected_q.push_back(oldest);
      end
      pending_count = expected_q.size();
    end
  end

endmodule

// ===== tb/csr_graph_builder_core_tb.sv =====
// csr_graph_builder_core_tb: stimulus and verdict for the csr graph builder core
// directed edge cases, then random graph sessions under idling
// depends on csrgb_pkg, csr_graph_builder_core and csr_graph_builder_core_checker
module csr_graph_builder_core_tb import csrgb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = CMD_READ_NB + 1'b1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = '1;
  localparam int RANDOM_REQUESTS = 1800;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  command = CMD_CLEAR;
  logic [VTX_W-1:0]  tail_vertex = '0;
  logic [VTX_W-1:0]  head_vertex = '0;
  logic [IDX_W-1:0]  read_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [VAL_W-1:0]  read_value;
  logic [VCNT_W-1:0] vertex_count;
  logic [ECNT_W-1:0] edge_count;
  logic [STAT_W-1:0] status;

  int fail_count;
  int pending;
  int checked;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int requests_sent = 0;
  int edges_loaded = 0;
  int sessions = 0;

  csr_graph_builder_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .tail_vertex_i  (tail_vertex),
    .head_vertex_i  (head_vertex),
    .read_index_i   (read_index),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .read_value_o   (read_value),
    .vertex_count_o (vertex_count),
    .edge_count_o   (edge_count),
    .status_o       (status)
  );

  csr_graph_builder_core_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .command_i      (command),
    .tail_vertex_i  (tail_vertex),
    .head_vertex_i  (head_vertex),
    .read_index_i   (read_index),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .read_value_i   (read_value),
    .vertex_count_i (vertex_count),
    .edge_count_i   (edge_count),
    .status_i       (status),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #10ms;
    $display("csr_graph_builder_core: mismatch");
    $finish;
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VTX_W-1:0] tail,
                              input logic [VTX_W-1:0] head, input logic [IDX_W-1:0] idx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    tail_vertex <= tail;
    head_vertex <= head;
    read_index  <= idx;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic load_edge(input logic [VTX_W-1:0] tail, input logic [VTX_W-1:0] head);
    send_request(CMD_LOAD, tail, head, IDX_W'($urandom));
    if (edges_loaded < DEF_EDGE_SLOTS) edges_loaded++;
  endtask

  task automatic clear_graph();
    send_request(CMD_CLEAR, VTX_W'($urandom), VTX_W'($urandom), IDX_W'($urandom));
    edges_loaded = 0;
  endtask

  task automatic build_graph();
    send_request(CMD_BUILD, VTX_W'($urandom), VTX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic read_row(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
    send_request(cmd, VTX_W'($urandom), VTX_W'($urandom), idx);
  endtask

  // reads spread over the valid range and just past it, sometimes anywhere
  task automatic random_reads(input int count, input int vspan);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 10)
        read_row($urandom_range(1) ? CMD_READ_OFF : CMD_READ_NB, IDX_W'($urandom));
      else if ($urandom_range(1))
        read_row(CMD_READ_OFF, IDX_W'($urandom_range(vspan + 2)));
      else
        read_row(CMD_READ_NB, IDX_W'($urandom_range(edges_loaded + 1)));
    end
  endtask

  task automatic send_noise(input int vspan);
    case ($urandom_range(3))
      0: read_row(CMD_READ_OFF, IDX_W'($urandom_range(vspan + 2)));
      1: read_row(CMD_READ_NB, IDX_W'($urandom));
      2: send_request(CMD_UNUSED_FIRST + CMD_W'($urandom_range(2)), VTX_W'($urandom),
                      VTX_W'($urandom), IDX_W'($urandom));
      default: build_graph();
    endcase
  endtask

  task automatic run_graph_session();
    int vspan;
    int n_edges;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) vspan = $urandom_range(1, 15);
    else if (pick < 90) vspan = $urandom_range(16, 127);
    else vspan = (1 << VTX_W) - 1;
    n_edges = ($urandom_range(99) < 80) ? $urandom_range(0, 20) : $urandom_range(21, 200);
    if ($urandom_range(99) < 85 || edges_loaded > DEF_EDGE_SLOTS - 300) clear_graph();
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(99) < 8) send_noise(vspan);
      load_edge(VTX_W'($urandom_range(vspan)), VTX_W'($urandom_range(vspan)));
    end
    build_graph();
    random_reads($urandom_range(4, 30), vspan);
    // a load after the build invalidates the rows until the next build
    if ($urandom_range(99) < 25) begin
      load_edge(VTX_W'($urandom_range(vspan)), VTX_W'($urandom_range(vspan)));
      random_reads($urandom_range(1, 3), vspan);
      build_graph();
      random_reads($urandom_range(2, 10), vspan);
    end
    sessions++;
  endtask

  initial begin
    int random_start;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    read_row(CMD_READ_OFF, '0);
    read_row(CMD_READ_NB, '0);
    build_graph();
    read_row(CMD_READ_OFF, IDX_W'(0));
    read_row(CMD_READ_OFF, IDX_W'(1));
    read_row(CMD_READ_OFF, IDX_W'(2));
    read_row(CMD_READ_NB, '0);
    send_request(CMD_UNUSED_FIRST, '1, '1, '1);
    send_request(CMD_UNUSED_LAST, '0, '0, '0);
    load_edge('0, '0);
    load_edge('1, '1);
    load_edge('1, '0);
    load_edge(VTX_W'(5), '1);
    load_edge('0, VTX_W'(7));
    build_graph();
    read_row(CMD_READ_OFF, IDX_W'(1));
    read_row(CMD_READ_OFF, IDX_W'(1023));
    read_row(CMD_READ_OFF, IDX_W'(1024));
    read_row(CMD_READ_OFF, IDX_W'(1025));
    read_row(CMD_READ_OFF, '1);
    read_row(CMD_READ_NB, IDX_W'(4));
    read_row(CMD_READ_NB, IDX_W'(5));
    load_edge(VTX_W'(3), VTX_W'(7));
    read_row(CMD_READ_NB, '0);
    clear_graph();
    read_row(CMD_READ_OFF, '0);

    random_start = requests_sent;
    while (requests_sent - random_start < RANDOM_REQUESTS) begin
      case (sessions % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      run_graph_session();
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("%0d requests sent: directed cases and %0d random graph sessions",
             requests_sent, sessions);
    $display("%0d results checked under four idling mixes", checked);
    if (fail_count == 0) begin
      $display("csr_graph_builder_core: match");
    end else begin
      $display("csr_graph_builder_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/csrgb_pkg.sv
design/csrgb_alu.sv
design/csr_graph_builder_core.sv
tb/csr_graph_builder_core_checker.sv
tb/csr_graph_builder_core_tb.sv
